[sv/dfu_pkg.sv]
// ----------------------------------------------------------------------------
// DFU request handler package
// Shared types, codes and constants for the DFU class request handler.
// ----------------------------------------------------------------------------
package dfu_pkg;

  // Field widths.
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned ACT_W   = 8;
  localparam int unsigned BLOCK_W = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned OP_W    = 2;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic REG_FLASH_BASE  = 1'b0;
  localparam logic REG_BLOCK_LIMIT = 1'b1;

  localparam logic [ADDR_W-1:0]  FLASH_BASE_RESET  = '0;
  localparam logic [BLOCK_W-1:0] BLOCK_LIMIT_RESET = 16'd256;

  localparam int unsigned BLOCK_BYTES_DEFAULT = 512;

  // A request is acted on only when one of these type bits is set.
  localparam logic [TYPE_W-1:0] REQ_TYPE_MASK = 8'h21;

  // DFU class request codes.
  localparam logic [ACT_W-1:0] ACT_DETACH    = 8'd0;
  localparam logic [ACT_W-1:0] ACT_DNLOAD    = 8'd1;
  localparam logic [ACT_W-1:0] ACT_UPLOAD    = 8'd2;
  localparam logic [ACT_W-1:0] ACT_GETSTATUS = 8'd3;
  localparam logic [ACT_W-1:0] ACT_GETSTATE  = 8'd5;
  localparam logic [ACT_W-1:0] ACT_ABORT     = 8'd6;

  // Reply lengths of the status queries.
  localparam logic [LEN_W-1:0] GETSTATUS_REPLY_LEN = 16'd6;
  localparam logic [LEN_W-1:0] GETSTATE_REPLY_LEN  = 16'd1;

  typedef enum logic [STATE_W-1:0] {
    DFU_IDLE    = 4'd2,
    DFU_DN_SYNC = 4'd3,
    DFU_DN_IDLE = 4'd5,
    DFU_UP_IDLE = 4'd9,
    DFU_ERROR   = 4'd10
  } dfu_state_e;

  typedef enum logic [OP_W-1:0] {
    MEM_NONE  = 2'd0,
    MEM_WRITE = 2'd1,
    MEM_READ  = 2'd2
  } dfu_mem_op_e;

  typedef struct packed {
    logic [TYPE_W-1:0]  request_type;
    logic [ACT_W-1:0]   action;
    logic [BLOCK_W-1:0] block_index;
    logic [LEN_W-1:0]   transfer_len;
  } dfu_req_t;

  typedef struct packed {
    logic [STATE_W-1:0] state_out;
    logic               status_out;
    logic [LEN_W-1:0]   reply_len;
    logic [OP_W-1:0]    mem_op;
    logic [ADDR_W-1:0]  mem_addr;
    logic [LEN_W-1:0]   mem_len;
    logic               write_final;
    logic               transfer_done;
  } dfu_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  flash_base;
    logic [BLOCK_W-1:0] block_limit;
  } dfu_cfg_t;

endpackage

[sv/dfu_request_state_machine_core.sv]
// ----------------------------------------------------------------------------
// DFU request state machine core
// Control plane of a USB DFU class request handler.
// ----------------------------------------------------------------------------
// Each setup request moves through two register stages: the input stage
// captures the request together with block_index * BLOCK_BYTES, and the
// result stage decodes it against the protocol state, adds the flash base
// and updates the state. A request is accepted every cycle while results are
// taken. The request is registered in the input stage and its result in the
// result stage, from which it is offered. The protocol state is updated in
// the result stage alone, so requests follow one another without a gap. A
// stalled result holds the pipeline; the input stage still takes one further
// request. Configuration should be written through the APB port only while
// no request is in flight; the block itself does not enforce this.
module dfu_request_state_machine_core import dfu_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  dfu_req_t              req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output dfu_rsp_t              rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PlenW = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned ProdW = BLOCK_W + PlenW;

  dfu_cfg_t cfg;

  dfu_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input stage.
  logic              s1_valid_q;
  dfu_req_t          s1_req_q;
  logic [ProdW-1:0]  s1_prod_q;
  logic [ProdW-1:0]  in_prod;

  // Protocol state.
  dfu_state_e         state_q, state_d;
  logic [BLOCK_W-1:0] pend_block_q, pend_block_d;
  logic [PlenW-1:0]   pend_len_q, pend_len_d;
  logic [ProdW-1:0]   pend_prod_q, pend_prod_d;
  logic               done_q, done_d;

  // Result stage.
  logic     out_valid_q;
  dfu_rsp_t out_q, out_d;

  logic              advance;
  logic              in_accept;
  logic              act_en;
  logic [ADDR_W-1:0] add_off;

  assign advance     = ~out_valid_q | rsp_ready_i;
  assign req_ready_o = advance | ~s1_valid_q;
  assign in_accept   = req_valid_i & req_ready_o;

  assign in_prod = ProdW'(req_i.block_index) * ProdW'(BLOCK_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q  <= req_i;
      s1_prod_q <= in_prod;
    end
  end

  assign act_en = |(s1_req_q.request_type & REQ_TYPE_MASK);

  always_comb begin
    state_d      = state_q;
    pend_block_d = pend_block_q;
    pend_len_d   = pend_len_q;
    pend_prod_d  = pend_prod_q;
    done_d       = done_q;
    out_d        = '0;
    add_off      = ADDR_W'(s1_prod_q);
    if (act_en) begin
      case (s1_req_q.action)
        ACT_DNLOAD: begin
          state_d      = DFU_DN_SYNC;
          pend_block_d = s1_req_q.block_index;
          pend_prod_d  = s1_prod_q;
          // Oversized downloads are clamped to one block.
          if (s1_req_q.transfer_len > LEN_W'(BLOCK_BYTES)) begin
            pend_len_d = PlenW'(BLOCK_BYTES);
          end else begin
            pend_len_d = s1_req_q.transfer_len[PlenW-1:0];
          end
        end
        ACT_UPLOAD: begin
          pend_block_d = s1_req_q.block_index;
          pend_prod_d  = s1_prod_q;
          if (s1_req_q.block_index == cfg.block_limit) begin
            state_d = DFU_IDLE;
          end else if (s1_req_q.block_index > cfg.block_limit) begin
            state_d = DFU_ERROR;
          end else begin
            state_d         = DFU_UP_IDLE;
            out_d.mem_op    = MEM_READ;
            out_d.mem_len   = s1_req_q.transfer_len;
            out_d.reply_len = s1_req_q.transfer_len;
          end
        end
        ACT_GETSTATUS: begin
          out_d.reply_len = GETSTATUS_REPLY_LEN;
          add_off         = ADDR_W'(pend_prod_q);
          if (state_q == DFU_DN_SYNC) begin
            if (pend_len_q == '0) begin
              state_d = DFU_IDLE;
              done_d  = 1'b1;
            end else if (pend_block_q >= cfg.block_limit) begin
              state_d = DFU_ERROR;
            end else begin
              state_d           = DFU_DN_IDLE;
              out_d.mem_op      = MEM_WRITE;
              out_d.mem_len     = LEN_W'(pend_len_q);
              out_d.write_final = (pend_len_q < PlenW'(BLOCK_BYTES));
            end
          end
        end
        ACT_GETSTATE: begin
          out_d.reply_len = GETSTATE_REPLY_LEN;
        end
        ACT_ABORT: begin
          state_d = DFU_IDLE;
        end
        default: ;
      endcase
    end
    if (out_d.mem_op != MEM_NONE) begin
      out_d.mem_addr = cfg.flash_base + add_off;
    end
    out_d.state_out     = state_d;
    out_d.status_out    = (state_d == DFU_ERROR);
    out_d.transfer_done = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= DFU_IDLE;
      pend_block_q <= '0;
      pend_len_q   <= '0;
      pend_prod_q  <= '0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        state_q      <= state_d;
        pend_block_q <= pend_block_d;
        pend_len_q   <= pend_len_d;
        pend_prod_q  <= pend_prod_d;
        done_q       <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

[sv/dfu_apb_regs.sv]
// ----------------------------------------------------------------------------
// DFU configuration registers
// APB register file holding the flash base address and the block limit.
// ----------------------------------------------------------------------------
module dfu_apb_regs import dfu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output dfu_cfg_t              cfg_o
);

  dfu_cfg_t cfg_q;
  logic     wr_en;
  logic     reg_idx;

  // Registers sit on 32-bit words, so the word index is the top address bit.
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_base  <= FLASH_BASE_RESET;
      cfg_q.block_limit <= BLOCK_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FLASH_BASE:  cfg_q.flash_base  <= pwdata[ADDR_W-1:0];
        REG_BLOCK_LIMIT: cfg_q.block_limit <= pwdata[BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLASH_BASE:  prdata = APB_DATA_W'(cfg_q.flash_base);
      REG_BLOCK_LIMIT: prdata = APB_DATA_W'(cfg_q.block_limit);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[sv/dfu_checker.sv]
// ----------------------------------------------------------------------------
// DFU request state machine checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module dfu_checker import dfu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     rsp_valid_i,
  input logic     rsp_ready_i,
  input dfu_rsp_t rsp_i
);

  // A result that is not taken stays, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("result transaction changed while stalled");

  // The status reports an address error exactly in the error state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_i.status_out == (rsp_i.state_out == DFU_ERROR))
    else $error("status does not match state");

  // Without a memory command, address, length and final mark are all zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.mem_op == MEM_NONE |->
      rsp_i.mem_addr == '0 && rsp_i.mem_len == '0 && !rsp_i.write_final)
    else $error("idle memory command carries data");

  // A flash write leaves download idle; a flash read leaves upload idle and
  // returns as many bytes as it reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.mem_op != MEM_NONE |->
      (rsp_i.mem_op == MEM_WRITE && rsp_i.state_out == DFU_DN_IDLE) ||
      (rsp_i.mem_op == MEM_READ && rsp_i.state_out == DFU_UP_IDLE &&
       rsp_i.reply_len == rsp_i.mem_len && !rsp_i.write_final))
    else $error("memory command inconsistent with state");

endmodule

bind dfu_request_state_machine_core dfu_checker u_dfu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_i       (rsp_o)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// DFU request state machine testbench
// Sends DFU class setup requests through the valid/ready request channel and
// checks every response against a cycle-free model of the protocol state,
// with random gaps and stalls on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb;
  import dfu_pkg::*;

  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned BLK_BYTES  = BLOCK_BYTES_DEFAULT;
  localparam logic [APB_ADDR_W-1:0] ADDR_FLASH_BASE  = {REG_FLASH_BASE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_BLOCK_LIMIT = {REG_BLOCK_LIMIT, 2'b00};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  req_valid_i;
  logic                  req_ready_o;
  dfu_req_t              req_i;
  logic                  rsp_valid_o;
  logic                  rsp_ready_i;
  dfu_rsp_t              rsp_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dfu_request_state_machine_core #(
    .BLOCK_BYTES(BLK_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mirror of the registers and of the protocol state.
  logic [ADDR_W-1:0]  cfg_base;
  logic [BLOCK_W-1:0] cfg_limit;
  dfu_state_e         mdl_state;
  logic               mdl_status;
  logic [BLOCK_W-1:0] dfu_block;
  logic [LEN_W-1:0]   dfu_len;
  logic               dfu_done;

  dfu_req_t req_pending[$];
  dfu_rsp_t rsp_expected[$];
  int       reqs_queued;
  int       err_count;
  int       req_gap;
  int       rsp_hold;
  logic     req_taken;
  logic     rsp_taken;
  logic     no_idle;

  function automatic logic [ADDR_W-1:0] flash_addr(input logic [BLOCK_W-1:0] blk);
    return cfg_base + ADDR_W'(blk) * ADDR_W'(BLK_BYTES);
  endfunction

  function automatic void enter_state(input dfu_state_e s);
    mdl_state  = s;
    mdl_status = (s == DFU_ERROR);
  endfunction

  // Advances the protocol state by one request and returns its response.
  function automatic dfu_rsp_t dfu_advance(input dfu_req_t rq);
    dfu_rsp_t r;
    r = '0;
    if ((rq.request_type & REQ_TYPE_MASK) != '0) begin
      case (rq.action)
        ACT_DNLOAD: begin
          enter_state(DFU_DN_SYNC);
          dfu_block = rq.block_index;
          dfu_len   = (rq.transfer_len > BLK_BYTES) ? LEN_W'(BLK_BYTES) : rq.transfer_len;
        end
        ACT_UPLOAD: begin
          dfu_block = rq.block_index;
          if (rq.block_index == cfg_limit) begin
            enter_state(DFU_IDLE);
          end else if (rq.block_index > cfg_limit) begin
            enter_state(DFU_ERROR);
          end else begin
            enter_state(DFU_UP_IDLE);
            r.mem_op    = MEM_READ;
            r.mem_addr  = flash_addr(rq.block_index);
            r.mem_len   = rq.transfer_len;
            r.reply_len = rq.transfer_len;
          end
        end
        ACT_GETSTATUS: begin
          if (mdl_state == DFU_DN_SYNC) begin
            if (dfu_len == '0) begin
              enter_state(DFU_IDLE);
              dfu_done = 1'b1;
            end else if (dfu_block >= cfg_limit) begin
              enter_state(DFU_ERROR);
            end else begin
              r.mem_op      = MEM_WRITE;
              r.mem_addr    = flash_addr(dfu_block);
              r.mem_len     = dfu_len;
              r.write_final = (dfu_len < BLK_BYTES);
              enter_state(DFU_DN_IDLE);
            end
          end
          r.reply_len = GETSTATUS_REPLY_LEN;
        end
        ACT_GETSTATE: r.reply_len = GETSTATE_REPLY_LEN;
        ACT_ABORT:    enter_state(DFU_IDLE);
        default: ;
      endcase
    end
    r.state_out     = mdl_state;
    r.status_out    = mdl_status;
    r.transfer_done = dfu_done;
    return r;
  endfunction

  function automatic string rsp_text(input dfu_rsp_t r);
    return $sformatf("state=%0d status=%0d reply=%0d op=%0d addr=%h len=%0d final=%0d done=%0d",
                     r.state_out, r.status_out, r.reply_len, r.mem_op, r.mem_addr,
                     r.mem_len, r.write_final, r.transfer_done);
  endfunction

  // Request driver: holds an offered transaction until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(req_valid_i && !req_taken)) begin
      if (req_gap > 0) begin
        req_gap     <= req_gap - 1;
        req_valid_i <= 1'b0;
      end else if (req_pending.size() > 0) begin
        req_i       <= req_pending.pop_front();
        req_valid_i <= 1'b1;
        req_gap     <= no_idle ? 0 : $urandom_range(0, 7);
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  // Response stall: a fresh hold-off is drawn after each response transaction.
  always @(negedge clk_i) begin
    if (rsp_taken) rsp_hold = no_idle ? 0 : $urandom_range(0, 7);
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_ready_i <= 1'b0;
      rsp_hold--;
    end else begin
      rsp_ready_i <= 1'b1;
    end
  end

  // Monitor: predicts on each request transaction, checks each response.
  always @(posedge clk_i) begin
    dfu_rsp_t exp_rsp;
    req_taken <= rst_ni && req_valid_i && req_ready_o;
    rsp_taken <= rst_ni && rsp_valid_o && rsp_ready_i;
    if (rst_ni && req_valid_i && req_ready_o) rsp_expected.push_back(dfu_advance(req_i));
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (rsp_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("Unexpected response: %s", rsp_text(rsp_o));
      end else begin
        exp_rsp = rsp_expected.pop_front();
        if (rsp_o.state_out !== exp_rsp.state_out || rsp_o.status_out !== exp_rsp.status_out ||
            rsp_o.reply_len !== exp_rsp.reply_len || rsp_o.mem_op !== exp_rsp.mem_op ||
            rsp_o.mem_addr !== exp_rsp.mem_addr || rsp_o.mem_len !== exp_rsp.mem_len ||
            rsp_o.write_final !== exp_rsp.write_final ||
            rsp_o.transfer_done !== exp_rsp.transfer_done) begin
          err_count++;
          if (err_count <= 10) begin
            $display("Response mismatch at %0t", $realtime);
            $display("  expected %s", rsp_text(exp_rsp));
            $display("  actual   %s", rsp_text(rsp_o));
          end
        end
      end
    end
  end

  task automatic push_req(input logic [TYPE_W-1:0] rtype, input logic [ACT_W-1:0] act,
                          input logic [BLOCK_W-1:0] blk, input logic [LEN_W-1:0] len);
    dfu_req_t rq;
    rq.request_type = rtype;
    rq.action       = act;
    rq.block_index  = blk;
    rq.transfer_len = len;
    req_pending.push_back(rq);
    reqs_queued++;
  endtask

  // Sender pause: everything queued has been sent and answered.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (req_pending.size() != 0 || req_valid_i || rsp_expected.size() != 0);
  endtask

  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (addr == ADDR_FLASH_BASE) cfg_base = data;
    else cfg_limit = data[BLOCK_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [TYPE_W-1:0] class_type();
    logic [TYPE_W-1:0] t;
    case ($urandom_range(0, 5))
      0: t = 8'h21;
      1: t = 8'hA1;
      2: t = 8'h01;
      3: t = 8'h20;
      default: begin
        t = TYPE_W'($urandom);
        if ((t & REQ_TYPE_MASK) == '0) t[0] = 1'b1;
      end
    endcase
    return t;
  endfunction

  // Blocks cluster around the limit so that both range checks are exercised.
  function automatic logic [BLOCK_W-1:0] pick_block();
    case ($urandom_range(0, 9))
      0: return cfg_limit;
      1: return cfg_limit + 1'b1;
      2: return '1;
      3: return BLOCK_W'($urandom);
      default: return (cfg_limit == '0) ? '0 : BLOCK_W'($urandom_range(0, cfg_limit - 1));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LEN_W'(BLK_BYTES);
      2: return LEN_W'(BLK_BYTES - 1);
      3: return LEN_W'(BLK_BYTES + 1);
      4: return '1;
      5: return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(1, BLK_BYTES));
    endcase
  endfunction

  // Mostly well-formed download and upload sessions, with some noise.
  task automatic queue_traffic(input int n);
    int target;
    int pick;
    target = reqs_queued + n;
    while (reqs_queued < target) begin
      pick = $urandom_range(0, 15);
      if (pick < 6) begin
        push_req(class_type(), ACT_DNLOAD, pick_block(), pick_len());
        if ($urandom_range(0, 5) == 0) begin
          push_req(class_type(), ACT_GETSTATE, BLOCK_W'($urandom), LEN_W'($urandom));
        end
        push_req(class_type(), ACT_GETSTATUS, BLOCK_W'($urandom), LEN_W'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          push_req(class_type(), ACT_GETSTATUS, BLOCK_W'($urandom), LEN_W'($urandom));
        end
      end else if (pick < 9) begin
        push_req(class_type(), ACT_UPLOAD, pick_block(), pick_len());
      end else if (pick == 9) begin
        push_req(class_type(), ACT_ABORT, BLOCK_W'($urandom), LEN_W'($urandom));
      end else if (pick == 10) begin
        push_req(class_type(), ACT_GETSTATE, BLOCK_W'($urandom), LEN_W'($urandom));
      end else if (pick == 11) begin
        push_req(class_type(), ACT_GETSTATUS, BLOCK_W'($urandom), LEN_W'($urandom));
      end else if (pick == 12) begin
        push_req(class_type(), ACT_DNLOAD, pick_block(), pick_len());
      end else if (pick == 13) begin
        push_req(TYPE_W'($urandom) & ~REQ_TYPE_MASK, ACT_W'($urandom),
                 BLOCK_W'($urandom), LEN_W'($urandom));
      end else begin
        push_req(TYPE_W'($urandom), ACT_W'($urandom), BLOCK_W'($urandom),
                 LEN_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    rsp_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    req_gap     = 0;
    rsp_hold    = 0;
    req_taken   = 1'b0;
    rsp_taken   = 1'b0;
    no_idle     = 1'b0;
    reqs_queued = 0;
    err_count   = 0;
    cfg_base    = FLASH_BASE_RESET;
    cfg_limit   = BLOCK_LIMIT_RESET;
    mdl_state   = DFU_IDLE;
    mdl_status  = 1'b0;
    dfu_block   = '0;
    dfu_len     = '0;
    dfu_done    = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset register values.
    push_req(8'h00, ACT_DNLOAD, 16'd1, 16'd16);
    push_req(8'hDE, ACT_UPLOAD, 16'd0, 16'd64);
    push_req(8'h21, ACT_DETACH, 16'hFFFF, 16'hFFFF);
    push_req(8'h21, 8'd4, 16'd0, 16'd0);
    push_req(8'hFF, 8'd255, 16'd0, 16'd0);
    push_req(8'h21, ACT_GETSTATUS, 16'd0, 16'd6);
    push_req(8'h21, ACT_DNLOAD, 16'd0, LEN_W'(BLK_BYTES));
    push_req(8'hA1, ACT_GETSTATUS, 16'd0, 16'd6);
    push_req(8'h21, ACT_DNLOAD, BLOCK_LIMIT_RESET - 1'b1, 16'd1);
    push_req(8'h21, ACT_GETSTATUS, 16'd0, 16'd6);
    push_req(8'h01, ACT_DNLOAD, 16'd7, 16'hFFFF);
    push_req(8'h20, ACT_GETSTATUS, 16'd0, 16'd6);
    push_req(8'h21, ACT_DNLOAD, BLOCK_LIMIT_RESET, 16'd10);
    push_req(8'h21, ACT_GETSTATUS, 16'd0, 16'd6);
    push_req(8'h21, ACT_GETSTATUS, 16'd0, 16'd6);
    push_req(8'hA1, ACT_GETSTATE, 16'd0, 16'd1);
    push_req(8'h21, ACT_ABORT, 16'd0, 16'd0);
    push_req(8'hA1, ACT_UPLOAD, 16'd0, 16'hFFFF);
    push_req(8'hA1, ACT_UPLOAD, BLOCK_LIMIT_RESET, 16'd64);
    push_req(8'hA1, ACT_UPLOAD, 16'hFFFF, 16'd64);
    push_req(8'h21, ACT_ABORT, 16'd0, 16'd0);
    push_req(8'h21, ACT_DNLOAD, 16'd3, 16'd0);
    push_req(8'h21, ACT_GETSTATUS, 16'd0, 16'd6);
    push_req(8'h21, ACT_GETSTATE, 16'd0, 16'd1);
    wait_quiet();

    // Ordinary base address with a short block range.
    cfg_write(ADDR_FLASH_BASE, 32'h0001_0000);
    cfg_write(ADDR_BLOCK_LIMIT, 32'd16);
    queue_traffic(200);
    wait_quiet();

    // Top of the address space: block addresses wrap; half of it without idling.
    cfg_write(ADDR_FLASH_BASE, 32'hFFFF_FFFF);
    cfg_write(ADDR_BLOCK_LIMIT, 32'h0000_FFFF);
    no_idle = 1'b1;
    queue_traffic(100);
    wait_quiet();
    no_idle = 1'b0;
    queue_traffic(100);
    wait_quiet();

    // No block may be accessed at all.
    cfg_write(ADDR_FLASH_BASE, 32'h0000_0000);
    cfg_write(ADDR_BLOCK_LIMIT, 32'd0);
    queue_traffic(100);
    wait_quiet();

    cfg_write(ADDR_FLASH_BASE, $urandom);
    cfg_write(ADDR_BLOCK_LIMIT, $urandom_range(1, 64));
    queue_traffic(300);
    wait_quiet();
    repeat (4) @(posedge clk_i);

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
